@@ rtl/gnf_pkg.sv @@
// gnf_pkg: shared types, constants and helpers for the fractal gradient noise core
// no dependencies; imported by gnf_ctrl, gnf_datapath and gradient_noise_fbm_core
package gnf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 5;
    localparam int MUL_W     = 20;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int VAL_W     = 20;
    localparam int Q_W       = 17;

    localparam logic [Q_W-1:0]   ONE_Q    = 17'h10000;
    localparam logic [MUL_W-1:0] FADE_K15 = 20'd983040;
    localparam logic [MUL_W-1:0] FADE_K10 = 20'd655360;
    localparam logic [MUL_W-1:0] FADE_K6  = 20'd6;
    localparam logic [PROD_W-1:0] RND_HALF = 40'd32768;

    localparam logic [1:0] CFG_DIM  = 2'd0;
    localparam logic [1:0] CFG_PERS = 2'd1;
    localparam logic [1:0] CFG_OCT  = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_INIT,
        ST_FADE_MUL,
        ST_FADE_WB,
        ST_LOOKUP,
        ST_LERP_MUL,
        ST_LERP_WB,
        ST_SAMP_MUL,
        ST_SAMP_WB,
        ST_AMP_MUL,
        ST_AMP_WB,
        ST_DIV_INIT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_FADE_P,
        MUL_FADE_B,
        MUL_FADE_W,
        MUL_LERP,
        MUL_SAMPLE,
        MUL_AMP
    } mul_sel_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_FADE,
        WB_LERP,
        WB_ACC,
        WB_AMP
    } wb_sel_t;

    typedef struct packed {
        logic             capture;
        logic             mem_write;
        logic             eval_init;
        logic             mul_en;
        mul_sel_t         mul_sel;
        wb_sel_t          wb_sel;
        logic             lookup;
        logic             next_oct;
        logic             div_init;
        logic             div_step;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic mode3d;
        logic last_oct;
        logic out_busy;
    } dp_stat_t;

    // rounded product: (p + half) >> FRAC_BITS
    function automatic logic [PROD_W-FRAC_BITS-1:0] round_q(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        s = p + RND_HALF;
        return s[PROD_W-1:FRAC_BITS];
    endfunction

    // gradient dot product, 2d uses the low three hash bits over (x, y)
    function automatic logic signed [VAL_W-1:0] grad_q(
        input logic [3:0]         h,
        input logic               is3d,
        input logic signed [17:0] x,
        input logic signed [17:0] y,
        input logic signed [17:0] z
    );
        logic signed [VAL_W-1:0] ex;
        logic signed [VAL_W-1:0] ey;
        logic signed [VAL_W-1:0] ez;
        logic signed [VAL_W-1:0] g;
        ex = VAL_W'(x);
        ey = VAL_W'(y);
        ez = VAL_W'(z);
        if (is3d)
        begin
            case (h)
                4'd0:    g = ex + ey;
                4'd1:    g = -ex + ey;
                4'd2:    g = ex - ey;
                4'd3:    g = -ex - ey;
                4'd4:    g = ex + ez;
                4'd5:    g = -ex + ez;
                4'd6:    g = ex - ez;
                4'd7:    g = -ex - ez;
                4'd8:    g = ey + ez;
                4'd9:    g = -ey + ez;
                4'd10:   g = ey - ez;
                4'd11:   g = -ey - ez;
                4'd12:   g = ex + ey;
                4'd13:   g = -ex + ey;
                4'd14:   g = -ey + ez;
                default: g = -ey - ez;
            endcase
        end
        else
        begin
            case (h[2:0])
                3'd0:    g = ex + ey;
                3'd1:    g = -ex + ey;
                3'd2:    g = ex - ey;
                3'd3:    g = -ex - ey;
                3'd4:    g = ex;
                3'd5:    g = -ex;
                3'd6:    g = ey;
                default: g = -ey;
            endcase
        end
        return g;
    endfunction

endpackage

@@ rtl/gnf_ctrl.sv @@
// gnf_ctrl: sequencer for the noise core, steps fade, lookup, lerp, weighting and divide
// depends on gnf_pkg; drives gnf_datapath through dp_cmd_t
module gnf_ctrl
    import gnf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  logic     s_tuser,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output logic     s_tready,
    output dp_cmd_t  cmd
);

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] fade_last;
    logic [IDX_W-1:0] lk_last;
    logic [IDX_W-1:0] lerp_last;
    logic             accept;
    logic             out_free;

    localparam logic [IDX_W-1:0] DIV_LAST = 5'd16;

    assign fade_last = stat.mode3d ? 5'd11 : 5'd7;
    assign lk_last   = stat.mode3d ? 5'd13 : 5'd5;
    assign lerp_last = stat.mode3d ? 5'd6  : 5'd2;
    assign accept    = s_tvalid && (state_reg == ST_IDLE);
    assign out_free  = !stat.out_busy || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_tuser == CMD_EVAL) ? ST_INIT : ST_LOAD;
                end
            end
            ST_LOAD:     state_next = ST_OUT;
            ST_INIT:
            begin
                state_next = ST_FADE_MUL;
                idx_next   = '0;
            end
            ST_FADE_MUL: state_next = ST_FADE_WB;
            ST_FADE_WB:
            begin
                if (idx_reg == fade_last)
                begin
                    state_next = ST_LOOKUP;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = ST_FADE_MUL;
                    idx_next   = idx_reg + 5'd1;
                end
            end
            ST_LOOKUP:
            begin
                if (idx_reg == lk_last)
                begin
                    state_next = ST_LERP_MUL;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + 5'd1;
                end
            end
            ST_LERP_MUL: state_next = ST_LERP_WB;
            ST_LERP_WB:
            begin
                if (idx_reg == lerp_last)
                begin
                    state_next = ST_SAMP_MUL;
                end
                else
                begin
                    state_next = ST_LERP_MUL;
                    idx_next   = idx_reg + 5'd1;
                end
            end
            ST_SAMP_MUL: state_next = ST_SAMP_WB;
            ST_SAMP_WB:  state_next = ST_AMP_MUL;
            ST_AMP_MUL:  state_next = ST_AMP_WB;
            ST_AMP_WB:
            begin
                idx_next   = '0;
                state_next = stat.last_oct ? ST_DIV_INIT : ST_FADE_MUL;
            end
            ST_DIV_INIT:
            begin
                state_next = ST_DIV;
                idx_next   = '0;
            end
            ST_DIV:
            begin
                if (idx_reg == DIV_LAST)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 5'd1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        cmd           = '0;
        cmd.mul_sel   = MUL_FADE_P;
        cmd.wb_sel    = WB_NONE;
        cmd.idx       = idx_reg;
        unique case (state_reg)
            ST_IDLE:     cmd.capture   = accept;
            ST_LOAD:     cmd.mem_write = 1'b1;
            ST_INIT:     cmd.eval_init = 1'b1;
            ST_FADE_MUL:
            begin
                cmd.mul_en = 1'b1;
                case (idx_reg[1:0])
                    2'd0:    cmd.mul_sel = MUL_FADE_P;
                    2'd1:    cmd.mul_sel = MUL_FADE_B;
                    default: cmd.mul_sel = MUL_FADE_W;
                endcase
            end
            ST_FADE_WB:  cmd.wb_sel = WB_FADE;
            ST_LOOKUP:   cmd.lookup = 1'b1;
            ST_LERP_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_LERP;
            end
            ST_LERP_WB:  cmd.wb_sel = WB_LERP;
            ST_SAMP_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SAMPLE;
            end
            ST_SAMP_WB:  cmd.wb_sel = WB_ACC;
            ST_AMP_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_AMP;
            end
            ST_AMP_WB:
            begin
                cmd.wb_sel   = WB_AMP;
                cmd.next_oct = !stat.last_oct;
            end
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_OUT:      cmd.out_load = out_free;
            default:     cmd.idx = idx_reg;
        endcase
    end

endmodule

@@ rtl/gnf_datapath.sv @@
// gnf_datapath: permutation memory, shared multiplier, lerp unit, octave sums and divider
// depends on gnf_pkg; commanded by gnf_ctrl
module gnf_datapath
    import gnf_pkg::*;
#(
    parameter int OCTAVE_MAX = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  dp_cmd_t       cmd,
    output dp_stat_t      stat,
    input  logic          cfg_valid,
    input  logic [1:0]    cfg_index,
    input  logic [16:0]   cfg_data,
    input  logic [111:0]  s_tdata,
    input  logic          s_tuser,
    input  logic          m_tready,
    output logic          m_tvalid,
    output logic [23:0]   m_tdata,
    output logic          m_tuser
);

    localparam int LG    = $clog2(OCTAVE_MAX + 1);
    localparam int ACC_W = 33 + LG;
    localparam int TOT_W = 17 + LG;
    localparam int NN_W  = ACC_W + 1;
    localparam int RW    = TOT_W + 2;
    localparam int RND_W = PROD_W - FRAC_BITS;

    // configuration
    logic             mode_reg;
    logic [16:0]      pers_reg;
    logic [4:0]       octcnt_reg;

    // captured item
    logic             eval_reg;
    logic [7:0]       tidx_reg;
    logic [7:0]       tval_reg;
    logic [31:0]      cx_reg;
    logic [31:0]      c1_reg;
    logic [31:0]      cz_reg;

    // table and lookups
    logic [7:0]       perm_mem [256];
    logic [7:0]       lk_reg [14];
    logic [7:0]       lk_addr;
    logic [7:0]       lk_base;
    logic [4:0]       k6;
    logic [3:0]       lk_sel;

    // arithmetic
    logic [Q_W-1:0]   fade_reg [3];
    logic [VAL_W-1:0] w_reg;
    logic [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0] lv_reg [7];
    logic signed [VAL_W-1:0] la_reg;
    logic             lneg_reg;
    logic [Q_W-1:0]   amp_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [TOT_W-1:0] tot_reg;
    logic [LG-1:0]    oct_reg;
    logic [LG-1:0]    oct_eff;

    // divider
    logic [RW-1:0]    rem_reg;
    logic [Q_W-1:0]   nlow_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [NN_W-1:0]  nn;
    logic [TOT_W:0]   dd;
    logic [RW-1:0]    trial;
    logic             ge;

    // output word
    logic             out_valid_reg;
    logic [Q_W-1:0]   out_noise_reg;
    logic             out_eval_reg;

    // combinational
    logic [15:0]      t_sel;
    logic [MUL_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_b;
    logic [RND_W-1:0] rnd;
    logic             dy;
    logic             dz;
    logic [7:0]       ha;
    logic [7:0]       hb;
    logic signed [17:0] x0;
    logic signed [17:0] x1;
    logic signed [17:0] ys;
    logic signed [17:0] zs;
    logic signed [VAL_W-1:0] ga;
    logic signed [VAL_W-1:0] gb;
    logic signed [VAL_W-1:0] op_a;
    logic signed [VAL_W-1:0] op_b;
    logic [Q_W-1:0]   op_f;
    logic signed [VAL_W:0] diff;
    logic [VAL_W-1:0] mag;
    logic signed [VAL_W:0] n_shift;
    logic [17:0]      s_clamp;
    logic [17:0]      s_inc;
    logic [Q_W-1:0]   sample;
    logic [Q_W-1:0]   pers_sat;
    logic [Q_W-1:0]   noise_clamp;

    assign pers_sat = (pers_reg > ONE_Q) ? ONE_Q : pers_reg;

    always_comb
    begin
        if (octcnt_reg == 5'd0)
            oct_eff = LG'(1);
        else if (32'(octcnt_reg) > OCTAVE_MAX)
            oct_eff = LG'(OCTAVE_MAX);
        else
            oct_eff = LG'(octcnt_reg);
    end

    assign stat.mode3d   = mode_reg;
    assign stat.last_oct = (oct_reg == oct_eff - LG'(1));
    assign stat.out_busy = out_valid_reg;

    // config writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            pers_reg   <= 17'd32768;
            octcnt_reg <= 5'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DIM:  mode_reg   <= cfg_data[0];
                CFG_PERS: pers_reg   <= cfg_data;
                CFG_OCT:  octcnt_reg <= cfg_data[4:0];
                default:  mode_reg   <= mode_reg;
            endcase
        end
    end

    // input capture, 2d folds z onto the second axis
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            eval_reg <= s_tuser;
            tidx_reg <= s_tdata[7:0];
            tval_reg <= s_tdata[15:8];
            cx_reg   <= s_tdata[47:16];
            c1_reg   <= mode_reg ? s_tdata[79:48] : s_tdata[111:80];
            cz_reg   <= s_tdata[111:80];
        end
        else if (cmd.next_oct)
        begin
            cx_reg <= {cx_reg[30:0], 1'b0};
            c1_reg <= {c1_reg[30:0], 1'b0};
            cz_reg <= {cz_reg[30:0], 1'b0};
        end
    end

    // lookup address: cells, then corners, then z neighbours
    assign k6     = cmd.idx - 5'd6;
    assign lk_sel = 4'd2 + {2'b00, k6[2:1]};
    assign lk_base = lk_reg[lk_sel];

    always_comb
    begin
        case (cmd.idx)
            5'd0:    lk_addr = cx_reg[23:16];
            5'd1:    lk_addr = cx_reg[23:16] + 8'd1;
            5'd2:    lk_addr = lk_reg[0] + c1_reg[23:16];
            5'd3:    lk_addr = lk_reg[0] + c1_reg[23:16] + 8'd1;
            5'd4:    lk_addr = lk_reg[1] + c1_reg[23:16];
            5'd5:    lk_addr = lk_reg[1] + c1_reg[23:16] + 8'd1;
            default: lk_addr = lk_base + cz_reg[23:16] + {7'd0, k6[0]};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
            perm_mem[tidx_reg] <= tval_reg;
        if (cmd.lookup)
            lk_reg[cmd.idx[3:0]] <= perm_mem[lk_addr];
    end

    // gradient corners for the current lerp
    always_comb
    begin
        case (cmd.idx[2:0])
            3'd1:    {dy, dz} = 2'b10;
            3'd3:    {dy, dz} = 2'b01;
            3'd4:    {dy, dz} = 2'b11;
            default: {dy, dz} = 2'b00;
        endcase
        if (mode_reg)
        begin
            ha = lk_reg[4'd6  + {2'b00, dy, dz}];
            hb = lk_reg[4'd10 + {2'b00, dy, dz}];
        end
        else
        begin
            ha = lk_reg[4'd2 + {3'b000, dy}];
            hb = lk_reg[4'd4 + {3'b000, dy}];
        end
    end

    assign x0 = $signed({2'b00, cx_reg[15:0]});
    assign x1 = $signed({2'b11, cx_reg[15:0]});
    assign ys = dy ? $signed({2'b11, c1_reg[15:0]}) : $signed({2'b00, c1_reg[15:0]});
    assign zs = dz ? $signed({2'b11, cz_reg[15:0]}) : $signed({2'b00, cz_reg[15:0]});
    assign ga = grad_q(ha[3:0], mode_reg, x0, ys, zs);
    assign gb = grad_q(hb[3:0], mode_reg, x1, ys, zs);

    always_comb
    begin
        case (cmd.idx[2:0])
            3'd2:
            begin
                op_a = lv_reg[0];
                op_b = lv_reg[1];
                op_f = fade_reg[1];
            end
            3'd5:
            begin
                op_a = lv_reg[3];
                op_b = lv_reg[4];
                op_f = fade_reg[1];
            end
            3'd6:
            begin
                op_a = lv_reg[2];
                op_b = lv_reg[5];
                op_f = fade_reg[2];
            end
            default:
            begin
                op_a = ga;
                op_b = gb;
                op_f = fade_reg[0];
            end
        endcase
    end

    assign diff = (VAL_W + 1)'(op_b) - (VAL_W + 1)'(op_a);
    assign mag  = diff[VAL_W] ? VAL_W'(-diff) : VAL_W'(diff);

    // octave sample mapped to [0,1]
    assign n_shift = (VAL_W + 1)'(mode_reg ? lv_reg[6] : lv_reg[2]) + (VAL_W + 1)'(ONE_Q);
    always_comb
    begin
        if (n_shift < 0)
            s_clamp = '0;
        else if (n_shift > (VAL_W + 1)'(2 * 65536))
            s_clamp = 18'd131072;
        else
            s_clamp = n_shift[17:0];
    end
    assign s_inc  = s_clamp + 18'd1;
    assign sample = s_inc[17:1];

    // shared multiplier operands
    always_comb
    begin
        case (cmd.idx[3:2])
            2'd0:    t_sel = cx_reg[15:0];
            2'd1:    t_sel = c1_reg[15:0];
            default: t_sel = cz_reg[15:0];
        endcase
        mul_a = MUL_W'(t_sel);
        mul_b = w_reg;
        case (cmd.mul_sel)
            MUL_FADE_P: mul_b = FADE_K15 - MUL_W'(t_sel) * FADE_K6;
            MUL_FADE_B: mul_b = FADE_K10 - w_reg;
            MUL_FADE_W: mul_b = w_reg;
            MUL_LERP:
            begin
                mul_a = mag;
                mul_b = MUL_W'(op_f);
            end
            MUL_SAMPLE:
            begin
                mul_a = MUL_W'(sample);
                mul_b = MUL_W'(amp_reg);
            end
            MUL_AMP:
            begin
                mul_a = MUL_W'(amp_reg);
                mul_b = MUL_W'(pers_sat);
            end
            default:    mul_b = w_reg;
        endcase
    end

    assign rnd = round_q(prod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
            if (cmd.mul_sel == MUL_LERP)
            begin
                la_reg   <= op_a;
                lneg_reg <= diff[VAL_W];
            end
        end
        case (cmd.wb_sel)
            WB_FADE:
            begin
                if (cmd.idx[1:0] == 2'd3)
                    fade_reg[cmd.idx[3:2]] <= rnd[Q_W-1:0];
                else
                    w_reg <= rnd[VAL_W-1:0];
            end
            WB_LERP:
            begin
                if (lneg_reg)
                    lv_reg[cmd.idx[2:0]] <= la_reg - $signed(rnd[VAL_W-1:0]);
                else
                    lv_reg[cmd.idx[2:0]] <= la_reg + $signed(rnd[VAL_W-1:0]);
            end
            default:
            begin
            end
        endcase
    end

    // octave sums and amplitude
    always_ff @(posedge clk)
    begin
        if (cmd.eval_init)
        begin
            amp_reg <= ONE_Q;
            acc_reg <= '0;
            tot_reg <= '0;
            oct_reg <= '0;
        end
        else
        begin
            if (cmd.wb_sel == WB_ACC)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg[33:0]);
                tot_reg <= tot_reg + TOT_W'(amp_reg);
            end
            if (cmd.wb_sel == WB_AMP)
                amp_reg <= rnd[Q_W-1:0];
            if (cmd.next_oct)
                oct_reg <= oct_reg + LG'(1);
        end
    end

    // restoring divide: q = floor((2 acc + total) / (2 total)), one bit a cycle
    assign nn    = {acc_reg, 1'b0} + NN_W'(tot_reg);
    assign dd    = {tot_reg, 1'b0};
    assign trial = {rem_reg[RW-2:0], nlow_reg[Q_W-1]};
    assign ge    = (trial >= RW'(dd));

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg  <= RW'(nn >> Q_W);
            nlow_reg <= nn[Q_W-1:0];
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= ge ? (trial - RW'(dd)) : trial;
            nlow_reg <= {nlow_reg[Q_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign noise_clamp = (quo_reg > ONE_Q) ? ONE_Q : quo_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_noise_reg <= eval_reg ? noise_clamp : '0;
            out_eval_reg  <= eval_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_noise_reg};
    assign m_tuser  = out_eval_reg;

`ifndef SYNTHESIS
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("output word overwritten while held");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < RW'(dd)))
        else $error("divider remainder out of range");

    a_div_total_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> (tot_reg >= TOT_W'(ONE_Q)))
        else $error("amplitude total below first octave weight");
`endif

endmodule

@@ rtl/gradient_noise_fbm_core.sv @@
// gradient_noise_fbm_core: top level of the fractal gradient noise engine
// depends on gnf_pkg, gnf_ctrl and gnf_datapath
//
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata 112b, s_tuser = cmd
// m_*      | out | m_tvalid/m_tready  | m_tdata 24b, m_tuser = was_evaluation
// cfg_*    | in  | cfg_valid/cfg_ready| cfg_index 2b, cfg_data 17b
//
// a load word is captured, written into the table, then loaded into the output register
// an evaluate word runs fade, lookup, lerp and weighting per octave, then the divide;
// the single shared multiplier (fade, lerp, weighting) and the one-port table sequence it
// reset is asynchronous and active low; the permutation table is not cleared
// a finished word waits in the output register while the next input word is accepted
module gradient_noise_fbm_core
    import gnf_pkg::*;
#(
    parameter int OCTAVE_MAX = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    // slave side
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [111:0]  s_tdata,   // table_index, table_value, coord_x, coord_y, coord_z
    input  logic          s_tuser,   // cmd
    // master side
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,   // noise_value, zero fill
    output logic          m_tuser,   // was_evaluation
    // register writes
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [16:0]   cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    gnf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    gnf_datapath #(
        .OCTAVE_MAX (OCTAVE_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
